FILE: sv/sli_pkg.sv
// Shared types and codes for the sorted list insert, find and remove block.
`default_nettype none

package sli_pkg;

    localparam int DATA_W = 32;

    // Operation codes carried on the input tuser.
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_FIND   = 2'd1;
    localparam logic [1:0] OP_REMOVE = 2'd2;

    // Status codes carried on the output tuser.
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_MISSING = 2'd1;
    localparam logic [1:0] STAT_FULL    = 2'd2;

    // Strobes broadcast from the sequencer to every cell of the row.
    typedef struct packed {
        logic compare;
        logic insert;
        logic remove;
    } cell_cmd_t;

endpackage

`default_nettype wire

FILE: sv/sli_cell.sv
// One storage cell of the sorted row: holds one entry and shifts with its neighbors.
`default_nettype none

module sli_cell
    import sli_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire cell_cmd_t                cmd,
    input  wire logic signed [DATA_W-1:0] key,
    input  wire logic                     left_lt,
    input  wire logic signed [DATA_W-1:0] left_value,
    input  wire logic                     left_occ,
    input  wire logic signed [DATA_W-1:0] right_value,
    input  wire logic                     right_occ,
    output logic signed [DATA_W-1:0]      value,
    output logic                          occ,
    output logic                          lt,
    output logic                          eq,
    output logic                          boundary
);

    logic signed [DATA_W-1:0] value_reg;
    logic signed [DATA_W-1:0] value_next;
    logic                     occ_reg;
    logic                     occ_next;
    logic                     lt_reg;
    logic                     eq_reg;

    // This cell is the first one whose entry is not less than the key.
    assign boundary = !lt_reg && left_lt;

    always_comb
    begin
        value_next = value_reg;
        occ_next   = occ_reg;
        if (cmd.insert && !lt_reg)
        begin
            if (boundary)
            begin
                value_next = key;
                occ_next   = 1'b1;
            end
            else
            begin
                value_next = left_value;
                occ_next   = left_occ;
            end
        end
        else if (cmd.remove && !lt_reg)
        begin
            value_next = right_value;
            occ_next   = right_occ;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
            lt_reg  <= 1'b0;
            eq_reg  <= 1'b0;
        end
        else
        begin
            occ_reg <= occ_next;
            if (cmd.compare)
            begin
                lt_reg <= occ_reg && (value_reg < key);
                eq_reg <= occ_reg && (value_reg == key);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    assign occ   = occ_reg;
    assign lt    = lt_reg;
    assign eq    = eq_reg;

endmodule

`default_nettype wire

FILE: sv/sorted_list_insert_find_remove_top.sv
// Top level of the sorted list: a row of compare-and-shift cells and its sequencer.
//
// The block keeps up to CAPACITY signed 32-bit entries in ascending order.
// Input words arrive on the s_axis channel: tuser carries the operation
// (insert, find or remove first occurrence) and tdata the signed value.
// Every input word yields exactly one output word on m_axis: tuser carries
// the status (done or found, not found, full) and tdata the position of the
// entry touched and the number of entries held afterwards.
// Each word passes a capture step, then a compare step in which every cell
// compares its entry with the key in parallel, then a shift step in which
// the row shifts by one place and the result is registered. The next input
// word is accepted only back in the capture step, so the block takes no new
// word before it is through with the last one.
// The output is held in a register, so a new input word is accepted while a
// result still waits; if the receiver stalls, the block halts in its shift
// step until the waiting result is taken.
// Reset empties the store at once (every cell is marked free) and clears the
// output valid; no clearing pass is needed.
`default_nettype none

module sorted_list_insert_find_remove_top
    import sli_pkg::*;
#(
    parameter int CAPACITY = 16
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [31:0] s_axis_tdata,   // [31:0] value
    input  wire logic [1:0]  s_axis_tuser,   // [1:0] opcode
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [3:0] position, [8:4] count, rest zero
    output logic [1:0]       m_axis_tuser    // [1:0] status
);

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CMP,
        ST_APPLY
    } state_t;

    state_t                   state_reg;
    state_t                   state_next;
    logic [1:0]               op_reg;
    logic [1:0]               op_next;
    logic signed [DATA_W-1:0] key_reg;
    logic signed [DATA_W-1:0] key_next;
    logic [CW-1:0]            count_reg;
    logic [CW-1:0]            count_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic [1:0]               out_status_reg;
    logic [1:0]               out_status_next;
    logic [3:0]               out_pos_reg;
    logic [3:0]               out_pos_next;
    logic [4:0]               out_count_reg;
    logic [4:0]               out_count_next;

    cell_cmd_t                cmd;
    logic [CAPACITY-1:0]      lt_vec;
    logic [CAPACITY-1:0]      eq_vec;
    logic [CAPACITY-1:0]      occ_vec;
    logic [CAPACITY-1:0]      bnd_vec;
    logic signed [DATA_W-1:0] value_arr [CAPACITY];

    logic [IW-1:0]            idx;
    logic                     found;
    logic                     full;
    logic                     go;
    logic [IW+3:0]            idx_wide;
    logic [CW+4:0]            count_wide;

    // The cell row. Cell 0 sees an always-less neighbor on its left so that it
    // becomes the boundary when no entry is less than the key; the last cell
    // pulls in a free slot from the right on a remove.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic                     left_lt;
        logic signed [DATA_W-1:0] left_value;
        logic                     left_occ;
        logic signed [DATA_W-1:0] right_value;
        logic                     right_occ;

        if (i == 0)
        begin : g_first
            assign left_lt    = 1'b1;
            assign left_value = key_reg;
            assign left_occ   = 1'b0;
        end
        else
        begin : g_inner
            assign left_lt    = lt_vec[i-1];
            assign left_value = value_arr[i-1];
            assign left_occ   = occ_vec[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_value = key_reg;
            assign right_occ   = 1'b0;
        end
        else
        begin : g_mid
            assign right_value = value_arr[i+1];
            assign right_occ   = occ_vec[i+1];
        end

        sli_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .cmd         (cmd),
            .key         (key_reg),
            .left_lt     (left_lt),
            .left_value  (left_value),
            .left_occ    (left_occ),
            .right_value (right_value),
            .right_occ   (right_occ),
            .value       (value_arr[i]),
            .occ         (occ_vec[i]),
            .lt          (lt_vec[i]),
            .eq          (eq_vec[i]),
            .boundary    (bnd_vec[i])
        );
    end

    // At most one cell is the boundary, so its index is an OR of the indices.
    always_comb
    begin
        idx = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            if (bnd_vec[i])
            begin
                idx = idx | IW'(i);
            end
        end
    end

    assign found = |(bnd_vec & eq_vec);
    assign full  = (count_reg == CW'(CAPACITY));
    assign go    = (state_reg == ST_APPLY) && (!out_valid_reg || m_axis_tready);

    always_comb
    begin
        cmd.compare = (state_reg == ST_CMP);
        cmd.insert  = go && (op_reg == OP_INSERT) && !full;
        cmd.remove  = go && (op_reg == OP_REMOVE) && found;
    end

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        key_next        = key_reg;
        count_next      = count_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_status_next = out_status_reg;
        out_pos_next    = out_pos_reg;
        out_count_next  = out_count_reg;
        idx_wide        = {4'b0, idx};
        count_wide      = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    op_next    = s_axis_tuser;
                    key_next   = signed'(s_axis_tdata);
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                state_next = ST_APPLY;
            end
            ST_APPLY:
            begin
                if (go)
                begin
                    out_status_next = STAT_MISSING;
                    out_pos_next    = 4'd0;
                    unique case (op_reg)
                        OP_INSERT:
                        begin
                            if (full)
                            begin
                                out_status_next = STAT_FULL;
                            end
                            else
                            begin
                                out_status_next = STAT_OK;
                                out_pos_next    = idx_wide[3:0];
                                count_next      = count_reg + CW'(1);
                            end
                        end
                        OP_FIND:
                        begin
                            if (found)
                            begin
                                out_status_next = STAT_OK;
                                out_pos_next    = idx_wide[3:0];
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (found)
                            begin
                                out_status_next = STAT_OK;
                                out_pos_next    = idx_wide[3:0];
                                count_next      = count_reg - CW'(1);
                            end
                        end
                        default:
                        begin
                            out_status_next = STAT_MISSING;
                        end
                    endcase
                    count_wide     = {5'b0, count_next};
                    out_count_next = count_wide[4:0];
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            op_reg         <= OP_INSERT;
            key_reg        <= '0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= STAT_OK;
            out_pos_reg    <= 4'd0;
            out_count_reg  <= 5'd0;
        end
        else
        begin
            state_reg      <= state_next;
            op_reg         <= op_next;
            key_reg        <= key_next;
            count_reg      <= count_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_pos_reg    <= out_pos_next;
            out_count_reg  <= out_count_next;
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'b0, out_count_reg, out_pos_reg};
    assign m_axis_tuser  = out_status_reg;

    // The occupied cells always number exactly the entry count.
    a_occ_count: assert property (@(posedge clk) disable iff (!rst_n)
        $countones(occ_vec) == int'(count_reg))
        else $error("occupied cells disagree with entry count");

    // Occupied cells form a solid run starting at cell 0.
    a_occ_packed: assert property (@(posedge clk) disable iff (!rst_n)
        ((occ_vec >> 1) & ~occ_vec) == '0)
        else $error("gap in occupied cells");

    // During the shift step at most one cell marks the insertion point.
    a_bnd_single: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_APPLY) |-> $onehot0(bnd_vec))
        else $error("more than one boundary cell");

    // A refused insert is only reported when the store is full.
    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_status_reg == STAT_FULL)) |-> full)
        else $error("full status with free space");

    // The entry count changes only in a shift step that issues an output.
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        !go |=> $stable(count_reg))
        else $error("entry count changed outside a shift step");

endmodule

`default_nettype wire
